// ===== rtl/core/morphological_gradient_3x3_macros.svh =====
// Assertion macros shared by the morphological gradient RTL.
// The macros expect the clock i_clk and the active-low reset i_rst_n in scope.
`ifndef MORPHOLOGICAL_GRADIENT_3X3_MACROS_SVH
`define MORPHOLOGICAL_GRADIENT_3X3_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define MG_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define MG_CHECK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mg_pkg.sv =====
// Package for the 3x3 morphological gradient block.
// Holds field widths, register codes, queue sizing and the column type.
// No dependencies.
package mg_pkg;

    localparam int PIX_W = 8;
    localparam int FW_W  = 13;
    localparam int FH_W  = 16;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 13'd4096;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
        logic             produce;
    } t_mg_col;

endpackage

// ===== rtl/core/mg_if.sv =====
// Stream interfaces for pixel requests and gradient results.
// Depends on mg_pkg for the field widths.
interface mg_pix_if import mg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output req_type, output pixel_value, input ready);
    modport sink (input valid, input req_type, input pixel_value, output ready);
endinterface

interface mg_res_if import mg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] gradient_value;
    logic             frame_last;

    modport source (output valid, output gradient_value, output frame_last, input ready);
    modport sink (input valid, input gradient_value, input frame_last, output ready);
endinterface

// ===== rtl/core/morphological_gradient_3x3.sv =====
// 3x3 morphological gradient over an 8-bit grayscale raster stream. Each accepted pixel
// yields, one row plus one pixel later, the maximum minus the minimum of its 3x3
// neighborhood, clipped at the frame borders. The block takes one item per clock and
// returns results at the same rate; an input transfer passes the line-store read
// register and the column queue on its way to the result register, and the input
// stalls only while the result receiver stalls and the queue fills. After the
// frame's last pixel, frame_width + 1 flush transfers drain the pending results, the last
// of which carries frame_last. The two line stores are single-port read, single-port write
// memories of MAX_WIDTH bytes and need no clearing after reset.
// Writing frame_width or frame_height restarts the frame.
module morphological_gradient_3x3 import mg_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    mg_pix_if.sink            i_pix,
    mg_res_if.source          o_res
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (XW > FW_W) ? XW : FW_W;

    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;

    logic            cfg_wr;
    logic [CW-1:0]   width_ext;
    logic [CW-1:0]   width_clamp;
    logic [XW-1:0]   width_act;
    logic [AW-1:0]   width_m1;
    logic [FH_W-1:0] height_act;
    logic [FH_W-1:0] height_m1;

    logic            q_push;
    t_mg_col         q_push_data;
    logic            q_pop;
    logic            q_valid;
    t_mg_col         q_head;
    logic [Q_CW-1:0] q_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2:2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2:2])
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    assign width_ext   = CW'(r_frame_width);
    assign width_clamp = (width_ext < CW'(2)) ? CW'(2) :
                         (width_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : width_ext;
    assign width_act   = width_clamp[XW-1:0];
    assign width_m1    = AW'(width_clamp - CW'(1));
    assign height_act  = (r_frame_height < FH_W'(2)) ? FH_W'(2) : r_frame_height;
    assign height_m1   = height_act - FH_W'(1);

    mg_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_wr),
        .i_width     (width_act),
        .i_height    (height_act),
        .i_pix       (i_pix),
        .i_q_count   (q_count),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    mg_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_head      (q_head),
        .o_count     (q_count)
    );

    mg_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_wr),
        .i_width_m1  (width_m1),
        .i_height_m1 (height_m1),
        .i_q_valid   (q_valid),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_res       (o_res)
    );

endmodule

// ===== rtl/core/mg_front.sv =====
// Front end: accepts requests, tracks the input position and owns the two line stores.
// Depends on mg_pkg and mg_pix_if.
module mg_front import mg_pkg::*; #(
    parameter int MAX_WIDTH = 4096,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int XW = $clog2(MAX_WIDTH + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic [XW-1:0]   i_width,
    input  logic [FH_W-1:0] i_height,
    mg_pix_if.sink          i_pix,
    input  logic [Q_CW-1:0] i_q_count,
    output logic            o_push,
    output t_mg_col         o_push_data
);

    logic [PIX_W-1:0] r_upper [MAX_WIDTH];
    logic [PIX_W-1:0] r_middle [MAX_WIDTH];

    logic [XW-1:0]    r_col;
    logic [FH_W-1:0]  r_row;
    logic             r_f1_valid;
    logic             r_f1_wr;
    logic [AW-1:0]    r_f1_addr;
    logic             r_f1_inside;
    logic             r_f1_produce;
    logic [PIX_W-1:0] r_f1_bot;
    logic [PIX_W-1:0] r_top_rd;
    logic [PIX_W-1:0] r_mid_rd;

    logic             frame_in;
    logic             col_inside;
    logic             take;
    logic             produce;
    logic [AW-1:0]    addr;
    logic [XW-1:0]    n_col;

    assign frame_in   = r_row >= i_height;
    assign col_inside = r_col < i_width;
    assign addr       = r_col[AW-1:0];
    assign n_col      = r_col + XW'(1);

    assign i_pix.ready = (i_q_count + Q_CW'(r_f1_valid)) < Q_CW'(Q_DEPTH);
    assign take = i_pix.valid && i_pix.ready && (frame_in || i_pix.req_type == REQ_PIXEL);
    assign produce = frame_in || (r_row >= FH_W'(2)) ||
                     (r_row == FH_W'(1) && r_col != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= take;
            if (i_clear) begin
                r_col <= '0;
                r_row <= '0;
            end else if (take) begin
                if (!frame_in) begin
                    if (n_col >= i_width) begin
                        r_col <= '0;
                        r_row <= r_row + FH_W'(1);
                    end else begin
                        r_col <= n_col;
                    end
                end else if (col_inside) begin
                    r_col <= n_col;
                end else begin
                    r_col <= '0;
                    r_row <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_top_rd     <= r_upper[addr];
            r_mid_rd     <= r_middle[addr];
            r_f1_wr      <= !frame_in;
            r_f1_addr    <= addr;
            r_f1_inside  <= col_inside;
            r_f1_produce <= produce;
            r_f1_bot     <= frame_in ? '0 : i_pix.pixel_value;
            if (!frame_in) begin
                r_middle[addr] <= i_pix.pixel_value;
            end
        end
        if (r_f1_valid && r_f1_wr) begin
            r_upper[r_f1_addr] <= r_mid_rd;
        end
    end

    assign o_push              = r_f1_valid;
    assign o_push_data.top     = r_f1_inside ? r_top_rd : '0;
    assign o_push_data.mid     = r_f1_inside ? r_mid_rd : '0;
    assign o_push_data.bot     = r_f1_bot;
    assign o_push_data.produce = r_f1_produce;

endmodule

// ===== rtl/core/mg_queue.sv =====
// Short queue of window columns between the front end and the back end.
// Depends on mg_pkg and the assertion macros.
`include "morphological_gradient_3x3_macros.svh"

module mg_queue import mg_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_mg_col         i_push_data,
    input  logic            i_pop,
    output logic            o_valid,
    output t_mg_col         o_head,
    output logic [Q_CW-1:0] o_count
);

    t_mg_col         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    `MG_CHECK(a_count_bound, r_count <= Q_CW'(Q_DEPTH), "queue count exceeds depth")
    `MG_CHECK_IMPL(a_no_overflow, i_push && !i_pop, r_count < Q_CW'(Q_DEPTH), "push into full queue")
    `MG_CHECK_IMPL(a_no_underflow, i_pop, r_count != '0, "pop from empty queue")

endmodule

// ===== rtl/core/mg_back.sv =====
// Back end: 3x3 window register file, border clipping, max minus min and output register.
// Depends on mg_pkg, mg_res_if and the assertion macros.
`include "morphological_gradient_3x3_macros.svh"

module mg_back import mg_pkg::*; #(
    parameter int MAX_WIDTH = 4096,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic [AW-1:0]   i_width_m1,
    input  logic [FH_W-1:0] i_height_m1,
    input  logic            i_q_valid,
    input  t_mg_col         i_head,
    output logic            o_pop,
    mg_res_if.source        o_res
);

    function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    logic [PIX_W-1:0] r_win [9];
    logic [AW-1:0]    r_out_col;
    logic [FH_W-1:0]  r_out_row;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_grad;
    logic             r_last;

    logic [PIX_W-1:0] win_next [9];
    logic [PIX_W-1:0] v_hi [9];
    logic [PIX_W-1:0] v_lo [9];
    logic [PIX_W-1:0] col_hi [3];
    logic [PIX_W-1:0] col_lo [3];
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
    logic [2:0]       col_ok;
    logic [2:0]       row_ok;
    logic             last;
    logic             emit;

    assign col_ok = {r_out_col < i_width_m1, 1'b1, r_out_col != '0};
    assign row_ok = {r_out_row < i_height_m1, 1'b1, r_out_row != '0};
    assign last   = (r_out_row >= i_height_m1) && (r_out_col >= i_width_m1);

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            win_next[k] = r_win[k + 3];
        end
        win_next[6] = i_head.top;
        win_next[7] = i_head.mid;
        win_next[8] = i_head.bot;
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
                v_hi[c * 3 + k] = (col_ok[c] && row_ok[k]) ? win_next[c * 3 + k] : '0;
                v_lo[c * 3 + k] = (col_ok[c] && row_ok[k]) ? win_next[c * 3 + k] : PIX_MAX;
            end
            col_hi[c] = max3(v_hi[c * 3], v_hi[c * 3 + 1], v_hi[c * 3 + 2]);
            col_lo[c] = min3(v_lo[c * 3], v_lo[c * 3 + 1], v_lo[c * 3 + 2]);
        end
        hi = max3(col_hi[0], col_hi[1], col_hi[2]);
        lo = min3(col_lo[0], col_lo[1], col_lo[2]);
    end

    assign o_pop = i_q_valid && (!r_out_valid || o_res.ready);
    assign emit  = o_pop && i_head.produce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_col   <= '0;
            r_out_row   <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= i_head.produce;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_clear) begin
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (emit) begin
                if (last) begin
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else if (r_out_col >= i_width_m1) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + FH_W'(1);
                end else begin
                    r_out_col <= r_out_col + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= win_next[k];
            end
        end
        if (emit) begin
            r_grad <= hi - lo;
            r_last <= last;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.gradient_value = r_grad;
    assign o_res.frame_last     = r_last;

    `MG_CHECK(a_col_in_frame, r_out_col <= i_width_m1, "output column beyond the row")
    `MG_CHECK(a_row_in_frame, r_out_row <= i_height_m1, "output row beyond the frame")
    `MG_CHECK_IMPL(a_pop_needs_column, o_pop, i_q_valid, "pop without a queued column")

endmodule
